### src/bpc_pkg.sv
// ----------------------------------------------------------------------------
// bpc_pkg
// Shared types, register map and constants of the pressure compensation block.
// ----------------------------------------------------------------------------
`default_nettype none

package bpc_pkg;

    localparam int DW = 32;
    localparam int AW = 5;

    typedef logic [DW-1:0] t_word;

    localparam logic [2:0] REG_AC1   = 3'd0;
    localparam logic [2:0] REG_AC2   = 3'd1;
    localparam logic [2:0] REG_AC3   = 3'd2;
    localparam logic [2:0] REG_AC4   = 3'd3;
    localparam logic [2:0] REG_AC5   = 3'd4;
    localparam logic [2:0] REG_AC6   = 3'd5;
    localparam logic [2:0] REG_B1_B2 = 3'd6;
    localparam logic [2:0] REG_MC_MD = 3'd7;

    localparam t_word C_B6_OFS   = 32'd4000;
    localparam t_word C_P_MUL    = 32'd3038;
    localparam t_word C_P_NEG    = 32'd7357;
    localparam t_word C_P_ADD    = 32'd3791;
    localparam t_word C_B4_OFS   = 32'd32768;
    localparam t_word C_B7_MUL   = 32'd50000;
    localparam t_word C_SIGN     = 32'h8000_0000;
    localparam logic [17:0] C_P_MAX = 18'h3ffff;

endpackage

`default_nettype wire

### src/bpc_if.sv
// ----------------------------------------------------------------------------
// bpc channel interfaces
// Valid/ready channels for raw reading pairs and compensated results.
// ----------------------------------------------------------------------------
`default_nettype none

interface bpc_in_if;
    logic        valid;
    logic        ready;
    logic [15:0] raw_temperature;
    logic [15:0] raw_pressure;

    modport source (output valid, output raw_temperature, output raw_pressure, input ready);
    modport sink   (input valid, input raw_temperature, input raw_pressure, output ready);
endinterface

interface bpc_out_if;
    logic               valid;
    logic               ready;
    logic signed [15:0] temperature_tenths;
    logic        [17:0] pressure_pa;
    logic               status;

    modport source (output valid, output temperature_tenths, output pressure_pa,
                     output status, input ready);
    modport sink   (input valid, input temperature_tenths, input pressure_pa,
                     input status, output ready);
endinterface

`default_nettype wire

### src/bpc_div.sv
// ----------------------------------------------------------------------------
// bpc_div
// Pipelined unsigned 32/32 restoring divider, one quotient bit per stage,
// with a side payload carried alongside and a per-stage ready chain.
// ----------------------------------------------------------------------------
`default_nettype none

module bpc_div
    import bpc_pkg::*;
#(
    parameter int SW = 8
) (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_valid,
    output      logic          o_ready,
    input  wire t_word         i_dividend,
    input  wire t_word         i_divisor,
    input  wire logic [SW-1:0] i_side,
    output      logic          o_valid,
    input  wire logic          i_ready,
    output      t_word         o_quot,
    output      logic [SW-1:0] o_side
);

    localparam int NS = DW;

    logic          r_v    [NS];
    t_word         r_rem  [NS];
    t_word         r_n    [NS];
    t_word         r_d    [NS];
    logic [SW-1:0] r_side [NS];

    logic          en     [NS];
    logic          pv     [NS];
    t_word         prem   [NS];
    t_word         pn     [NS];
    t_word         pd     [NS];
    logic [SW-1:0] pside  [NS];
    t_word         n_rem  [NS];
    t_word         n_n    [NS];

    genvar k;
    generate
        for (k = 0; k < NS; k++) begin : g_st
            logic [DW:0] rsh;
            logic [DW:0] diff;

            if (k == 0) begin : g_first
                assign pv[k]    = i_valid;
                assign prem[k]  = '0;
                assign pn[k]    = i_dividend;
                assign pd[k]    = i_divisor;
                assign pside[k] = i_side;
            end else begin : g_next
                assign pv[k]    = r_v[k-1];
                assign prem[k]  = r_rem[k-1];
                assign pn[k]    = r_n[k-1];
                assign pd[k]    = r_d[k-1];
                assign pside[k] = r_side[k-1];
            end

            if (k == NS-1) begin : g_last
                assign en[k] = !r_v[k] || i_ready;
            end else begin : g_mid
                assign en[k] = !r_v[k] || en[k+1];
            end

            assign rsh      = {prem[k], pn[k][DW-1]};
            assign diff     = rsh - {1'b0, pd[k]};
            assign n_rem[k] = diff[DW] ? rsh[DW-1:0] : diff[DW-1:0];
            assign n_n[k]   = {pn[k][DW-2:0], !diff[DW]};

            always_ff @(posedge i_clk) begin
                if (!i_rst_n) begin
                    r_v[k] <= 1'b0;
                end else if (en[k]) begin
                    r_v[k] <= pv[k];
                end
            end

            always_ff @(posedge i_clk) begin
                if (en[k]) begin
                    r_rem[k]  <= n_rem[k];
                    r_n[k]    <= n_n[k];
                    r_d[k]    <= pd[k];
                    r_side[k] <= pside[k];
                end
            end
        end
    endgenerate

    assign o_ready = en[0];
    assign o_valid = r_v[NS-1];
    assign o_quot  = r_n[NS-1];
    assign o_side  = r_side[NS-1];

endmodule

`default_nettype wire

### src/barometric_pressure_compensation.sv
// ----------------------------------------------------------------------------
// barometric_pressure_compensation
// Integer temperature and pressure compensation of a barometric sensor.
// ----------------------------------------------------------------------------
// Takes one raw temperature/pressure word per cycle while the output is not
// stalled and returns one result word per input, in order, through twelve
// arithmetic register stages plus two 32-stage dividers that retire one
// quotient bit per stage. Each stage holds under backpressure and bubbles
// close up. Calibration registers sit on the APB port at byte address 4*i and
// must be written while no word is in flight. status is set when a divisor is
// zero; temperature is then zero too if the temperature divisor was the one.
`default_nettype none

module barometric_pressure_compensation
    import bpc_pkg::*;
(
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    bpc_in_if.sink             i_in,
    bpc_out_if.source          o_out,
    input  wire logic          psel,
    input  wire logic          penable,
    input  wire logic          pwrite,
    input  wire logic [AW-1:0] paddr,
    input  wire t_word         pwdata,
    output      t_word         prdata,
    output      logic          pready
);

    localparam int S1W = 50;
    localparam int S2W = 19;

    logic [15:0] r_ac1, r_ac2, r_ac3, r_ac4, r_ac5, r_ac6;
    t_word       r_b1b2, r_mcmd;
    logic [2:0]  idx;

    assign idx    = paddr[AW-1:2];
    assign pready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ac1  <= '0;
            r_ac2  <= '0;
            r_ac3  <= '0;
            r_ac4  <= '0;
            r_ac5  <= '0;
            r_ac6  <= '0;
            r_b1b2 <= '0;
            r_mcmd <= '0;
        end else if (psel && penable && pwrite) begin
            unique case (idx)
                REG_AC1:   r_ac1  <= pwdata[15:0];
                REG_AC2:   r_ac2  <= pwdata[15:0];
                REG_AC3:   r_ac3  <= pwdata[15:0];
                REG_AC4:   r_ac4  <= pwdata[15:0];
                REG_AC5:   r_ac5  <= pwdata[15:0];
                REG_AC6:   r_ac6  <= pwdata[15:0];
                REG_B1_B2: r_b1b2 <= pwdata;
                REG_MC_MD: r_mcmd <= pwdata;
                default:   ;
            endcase
        end
    end

    always_comb begin
        unique case (idx)
            REG_AC1:   prdata = {16'b0, r_ac1};
            REG_AC2:   prdata = {16'b0, r_ac2};
            REG_AC3:   prdata = {16'b0, r_ac3};
            REG_AC4:   prdata = {16'b0, r_ac4};
            REG_AC5:   prdata = {16'b0, r_ac5};
            REG_AC6:   prdata = {16'b0, r_ac6};
            REG_B1_B2: prdata = r_b1b2;
            REG_MC_MD: prdata = r_mcmd;
            default:   prdata = '0;
        endcase
    end

    t_word ac1s, ac2s, ac3s, ac4u, ac5u, ac6u, b1s, b2s, mcs, mds;
    assign ac1s = {{16{r_ac1[15]}}, r_ac1};
    assign ac2s = {{16{r_ac2[15]}}, r_ac2};
    assign ac3s = {{16{r_ac3[15]}}, r_ac3};
    assign ac4u = {16'b0, r_ac4};
    assign ac5u = {16'b0, r_ac5};
    assign ac6u = {16'b0, r_ac6};
    assign b1s  = {{16{r_b1b2[31]}}, r_b1b2[31:16]};
    assign b2s  = {{16{r_b1b2[15]}}, r_b1b2[15:0]};
    assign mcs  = {{16{r_mcmd[31]}}, r_mcmd[31:16]};
    assign mds  = {{16{r_mcmd[15]}}, r_mcmd[15:0]};

    // stage valids and enables
    logic r1_v, r2_v, r3_v, r4_v, r5_v, r6_v, r7_v, r8_v, r9_v;
    logic r10_v, r11_v, r12_v;
    logic en1, en2, en3, en4, en5, en6, en7, en8, en9, en10, en11, en12;
    logic d1_rdy, d1_v, d2_rdy, d2_v;

    assign en12 = !r12_v || o_out.ready;
    assign en11 = !r11_v || en12;
    assign en10 = !r10_v || en11;
    assign en9  = !r9_v  || d2_rdy;
    assign en8  = !r8_v  || en9;
    assign en7  = !r7_v  || en8;
    assign en6  = !r6_v  || en7;
    assign en5  = !r5_v  || en6;
    assign en4  = !r4_v  || en5;
    assign en3  = !r3_v  || en4;
    assign en2  = !r2_v  || d1_rdy;
    assign en1  = !r1_v  || en2;
    assign i_in.ready = en1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r1_v  <= 1'b0;
            r2_v  <= 1'b0;
            r3_v  <= 1'b0;
            r4_v  <= 1'b0;
            r5_v  <= 1'b0;
            r6_v  <= 1'b0;
            r7_v  <= 1'b0;
            r8_v  <= 1'b0;
            r9_v  <= 1'b0;
            r10_v <= 1'b0;
            r11_v <= 1'b0;
            r12_v <= 1'b0;
        end else begin
            if (en1)  r1_v  <= i_in.valid;
            if (en2)  r2_v  <= r1_v;
            if (en3)  r3_v  <= d1_v;
            if (en4)  r4_v  <= r3_v;
            if (en5)  r5_v  <= r4_v;
            if (en6)  r6_v  <= r5_v;
            if (en7)  r7_v  <= r6_v;
            if (en8)  r8_v  <= r7_v;
            if (en9)  r9_v  <= r8_v;
            if (en10) r10_v <= d2_v;
            if (en11) r11_v <= r10_v;
            if (en12) r12_v <= r11_v;
        end
    end

    // S1: (ut - ac6) * ac5
    t_word       r1_prod;
    logic [15:0] r1_up;
    t_word       n1_d;
    assign n1_d = {16'b0, i_in.raw_temperature} - ac6u;

    always_ff @(posedge i_clk) begin
        if (en1) begin
            r1_prod <= n1_d * ac5u;
            r1_up   <= i_in.raw_pressure;
        end
    end

    // S2: x1, divisor, operand magnitudes
    t_word       n2_x1, n2_den, n2_num;
    t_word       r2_x1, r2_na, r2_da;
    logic        r2_neg, r2_dz;
    logic [15:0] r2_up;
    assign n2_x1  = $signed(r1_prod) >>> 15;
    assign n2_den = n2_x1 + mds;
    assign n2_num = mcs << 11;

    always_ff @(posedge i_clk) begin
        if (en2) begin
            r2_x1  <= n2_x1;
            r2_na  <= n2_num[31] ? -n2_num : n2_num;
            r2_da  <= n2_den[31] ? -n2_den : n2_den;
            r2_neg <= n2_num[31] ^ n2_den[31];
            r2_dz  <= (n2_den == '0);
            r2_up  <= r1_up;
        end
    end

    t_word          d1_q;
    logic [S1W-1:0] d1_side;

    bpc_div #(.SW(S1W)) u_div_t (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_valid    (r2_v),
        .o_ready    (d1_rdy),
        .i_dividend (r2_na),
        .i_divisor  (r2_da),
        .i_side     ({r2_x1, r2_neg, r2_dz, r2_up}),
        .o_valid    (d1_v),
        .i_ready    (en3),
        .o_quot     (d1_q),
        .o_side     (d1_side)
    );

    // S3: b5, temperature, b6
    t_word       n3_x2, n3_b5, n3_t;
    logic [15:0] n3_temp;
    t_word       r3_b6;
    logic [15:0] r3_temp, r3_up;
    logic        r3_dz;
    assign n3_x2 = d1_side[17] ? -d1_q : d1_q;
    assign n3_b5 = d1_side[S1W-1:18] + n3_x2;
    assign n3_t  = $signed(n3_b5 + 32'd8) >>> 4;

    always_comb begin
        if ($signed(n3_t) > $signed(32'sd32767)) begin
            n3_temp = 16'h7fff;
        end else if ($signed(n3_t) < $signed(-32'sd32768)) begin
            n3_temp = 16'h8000;
        end else begin
            n3_temp = n3_t[15:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (en3) begin
            r3_b6   <= n3_b5 - C_B6_OFS;
            r3_temp <= n3_temp;
            r3_dz   <= d1_side[16];
            r3_up   <= d1_side[15:0];
        end
    end

    // S4: products of b6
    t_word       r4_psq, r4_pa2, r4_pa3;
    logic [15:0] r4_temp, r4_up;
    logic        r4_dz;

    always_ff @(posedge i_clk) begin
        if (en4) begin
            r4_psq  <= r3_b6 * r3_b6;
            r4_pa2  <= ac2s * r3_b6;
            r4_pa3  <= ac3s * r3_b6;
            r4_temp <= r3_temp;
            r4_up   <= r3_up;
            r4_dz   <= r3_dz;
        end
    end

    // S5: scale
    t_word       r5_sq, r5_x2a, r5_x1c;
    logic [15:0] r5_temp, r5_up;
    logic        r5_dz;

    always_ff @(posedge i_clk) begin
        if (en5) begin
            r5_sq   <= $signed(r4_psq) >>> 12;
            r5_x2a  <= $signed(r4_pa2) >>> 11;
            r5_x1c  <= $signed(r4_pa3) >>> 13;
            r5_temp <= r4_temp;
            r5_up   <= r4_up;
            r5_dz   <= r4_dz;
        end
    end

    // S6: b1, b2 products
    t_word       r6_pb2, r6_pb1, r6_x2a, r6_x1c;
    logic [15:0] r6_temp, r6_up;
    logic        r6_dz;

    always_ff @(posedge i_clk) begin
        if (en6) begin
            r6_pb2  <= b2s * r5_sq;
            r6_pb1  <= b1s * r5_sq;
            r6_x2a  <= r5_x2a;
            r6_x1c  <= r5_x1c;
            r6_temp <= r5_temp;
            r6_up   <= r5_up;
            r6_dz   <= r5_dz;
        end
    end

    // S7: b3 and x3
    t_word       n7_x3, n7_v, n7_w;
    t_word       r7_b3, r7_x3;
    logic [15:0] r7_temp, r7_up;
    logic        r7_dz;
    assign n7_x3 = t_word'($signed(r6_pb2) >>> 11) + r6_x2a;
    assign n7_v  = (ac1s << 2) + n7_x3 + 32'd2;
    assign n7_w  = r6_x1c + t_word'($signed(r6_pb1) >>> 16) + 32'd2;

    always_ff @(posedge i_clk) begin
        if (en7) begin
            r7_b3   <= $signed(n7_v + (n7_v[31] ? 32'd3 : 32'd0)) >>> 2;
            r7_x3   <= $signed(n7_w) >>> 2;
            r7_temp <= r6_temp;
            r7_up   <= r6_up;
            r7_dz   <= r6_dz;
        end
    end

    // S8: b4 product, b7
    t_word       r8_m4, r8_b7;
    logic [15:0] r8_temp;
    logic        r8_dz;

    always_ff @(posedge i_clk) begin
        if (en8) begin
            r8_m4   <= ac4u * (r7_x3 + C_B4_OFS);
            r8_b7   <= ({16'b0, r7_up} - r7_b3) * C_B7_MUL;
            r8_temp <= r7_temp;
            r8_dz   <= r7_dz;
        end
    end

    // S9: divider operands
    t_word       r9_dvd;
    logic [16:0] r9_b4;
    logic [15:0] r9_temp;
    logic        r9_dz, r9_bz, r9_msb;
    logic [16:0] n9_b4;
    assign n9_b4 = r8_m4[31:15];

    always_ff @(posedge i_clk) begin
        if (en9) begin
            r9_b4   <= n9_b4;
            r9_bz   <= (n9_b4 == '0);
            r9_msb  <= (r8_b7 >= C_SIGN);
            r9_dvd  <= (r8_b7 >= C_SIGN) ? r8_b7 : (r8_b7 << 1);
            r9_temp <= r8_temp;
            r9_dz   <= r8_dz;
        end
    end

    t_word          d2_q;
    logic [S2W-1:0] d2_side;

    bpc_div #(.SW(S2W)) u_div_p (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_valid    (r9_v),
        .o_ready    (d2_rdy),
        .i_dividend (r9_dvd),
        .i_divisor  ({15'b0, r9_b4}),
        .i_side     ({r9_temp, r9_dz, r9_bz, r9_msb}),
        .o_valid    (d2_v),
        .i_ready    (en10),
        .o_quot     (d2_q),
        .o_side     (d2_side)
    );

    // S10: p, p^2 term, linear term
    t_word       n10_p, n10_a;
    t_word       r10_p, r10_sqa, r10_m7;
    logic [15:0] r10_temp;
    logic        r10_dz, r10_bz;
    assign n10_p = d2_side[0] ? (d2_q << 1) : d2_q;
    assign n10_a = $signed(n10_p) >>> 8;

    always_ff @(posedge i_clk) begin
        if (en10) begin
            r10_p    <= n10_p;
            r10_sqa  <= n10_a * n10_a;
            r10_m7   <= C_P_NEG * n10_p;
            r10_temp <= d2_side[S2W-1:3];
            r10_dz   <= d2_side[2];
            r10_bz   <= d2_side[1];
        end
    end

    // S11: correction terms
    t_word       r11_p, r11_x1, r11_x2;
    logic [15:0] r11_temp;
    logic        r11_dz, r11_bz;
    t_word       n11_m;
    assign n11_m = r10_sqa * C_P_MUL;

    always_ff @(posedge i_clk) begin
        if (en11) begin
            r11_p    <= r10_p;
            r11_x1   <= $signed(n11_m) >>> 16;
            r11_x2   <= $signed(-r10_m7) >>> 16;
            r11_temp <= r10_temp;
            r11_dz   <= r10_dz;
            r11_bz   <= r10_bz;
        end
    end

    // S12: final pressure, saturate, output word
    t_word       n12_p;
    logic [17:0] n12_pres;
    logic [17:0] r12_pres;
    logic [15:0] r12_temp;
    logic        r12_st, r12_dz;
    assign n12_p = r11_p + t_word'($signed(r11_x1 + r11_x2 + C_P_ADD) >>> 4);

    always_comb begin
        if (n12_p[31]) begin
            n12_pres = '0;
        end else if (n12_p > {14'b0, C_P_MAX}) begin
            n12_pres = C_P_MAX;
        end else begin
            n12_pres = n12_p[17:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (en12) begin
            r12_pres <= (r11_dz || r11_bz) ? '0 : n12_pres;
            r12_temp <= r11_dz ? '0 : r11_temp;
            r12_st   <= r11_dz || r11_bz;
            r12_dz   <= r11_dz;
        end
    end

    assign o_out.valid              = r12_v;
    assign o_out.temperature_tenths = r12_temp;
    assign o_out.pressure_pa        = r12_pres;
    assign o_out.status             = r12_st;

    a_hold_s3: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r3_v && !en4 |=> r3_v)
        else $error("stage 3 word dropped under stall");

    a_tdiv_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r12_v && r12_dz |-> r12_st && r12_temp == '0 && r12_pres == '0)
        else $error("zero temperature divisor not flagged");

    a_rst_idle: assert property (@(posedge i_clk)
        !i_rst_n |=> !r12_v && !r1_v)
        else $error("valid after reset");

endmodule

`default_nettype wire
